// File: design/utrb_pkg.sv
// Shared types and codes for the UART transmit and receive ring buffers.
`default_nettype none

package utrb_pkg;

   // Event codes carried by the request mode field.
   typedef enum logic [1:0] {
      MODE_WRITE = 2'd0,
      MODE_READ  = 2'd1,
      MODE_RECV  = 2'd2,
      MODE_DONE  = 2'd3
   } mode_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic send_direct;   // idle transmitter: send the written byte now
      logic tx_push;       // store the written byte in the transmit queue
      logic tx_dec;        // transmitter finished one byte
      logic tx_pop;        // fetch the next queued transmit byte
      logic rx_push;       // store the received byte
      logic rx_pop;        // fetch the oldest received byte
      logic accepted;      // accepted flag for an immediate result
      logic overrun;       // overrun flag for an immediate result
      logic load_now;      // load the result register from this transaction
      logic load_fetch;    // load the result register from fetched memory data
      logic fetch_rx;      // fetched data came from the receive queue
   } cmd_type;

   // Queue status from the datapath to the controller.
   typedef struct packed {
      logic tx_zero;
      logic tx_one;
      logic tx_full;
      logic rx_zero;
      logic rx_full;
   } stat_type;

endpackage : utrb_pkg

`default_nettype wire

// File: design/utrb_dp.sv
// Datapath of the ring buffers: queue memories, pointers, counts and result register.
`default_nettype none

module utrb_dp
   import utrb_pkg::*;
#(
   parameter int QUEUE_DEPTH = 256,
   parameter int PTR_W       = $clog2(QUEUE_DEPTH),
   parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [7:0]       req_data,
   input  wire cmd_type          cmd,
   output stat_type             stat,
   output logic                  rsp_accepted,
   output logic [7:0]            rsp_read_data,
   output logic                  rsp_send_valid,
   output logic [7:0]            rsp_send_data,
   output logic                  rsp_overrun,
   output logic [CNT_W-1:0]      rsp_tx_level,
   output logic [CNT_W-1:0]      rsp_rx_level
);

   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   logic [7:0]       tx_mem_ff [QUEUE_DEPTH];
   logic [7:0]       rx_mem_ff [QUEUE_DEPTH];
   logic [7:0]       tx_rd_ff;
   logic [7:0]       rx_rd_ff;
   logic [PTR_W-1:0] tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic [PTR_W-1:0] rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [CNT_W-1:0] tx_count_ff, tx_count_in, rx_count_ff, rx_count_in;
   logic             accepted_ff, send_valid_ff, overrun_ff;
   logic [7:0]       read_data_ff, send_data_ff;

   // Pointer advance with wrap at the queue depth.
   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_LAST) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   // Status toward the controller.
   always_comb begin
      stat.tx_zero = (tx_count_ff == '0);
      stat.tx_one  = (tx_count_ff == CNT_ONE);
      stat.tx_full = (tx_count_ff == CNT_FULL);
      stat.rx_zero = (rx_count_ff == '0);
      stat.rx_full = (rx_count_ff == CNT_FULL);
   end

   // Next pointer and count values.
   always_comb begin
      tx_head_in  = cmd.tx_push ? advance(tx_head_ff) : tx_head_ff;
      tx_tail_in  = cmd.tx_pop  ? advance(tx_tail_ff) : tx_tail_ff;
      rx_head_in  = cmd.rx_push ? advance(rx_head_ff) : rx_head_ff;
      rx_tail_in  = cmd.rx_pop  ? advance(rx_tail_ff) : rx_tail_ff;

      tx_count_in = tx_count_ff;
      if (cmd.send_direct) begin
         tx_count_in = CNT_ONE;
      end else if (cmd.tx_push) begin
         tx_count_in = tx_count_ff + CNT_ONE;
      end else if (cmd.tx_dec) begin
         tx_count_in = tx_count_ff - CNT_ONE;
      end

      rx_count_in = rx_count_ff;
      if (cmd.rx_push) begin
         rx_count_in = rx_count_ff + CNT_ONE;
      end else if (cmd.rx_pop) begin
         rx_count_in = rx_count_ff - CNT_ONE;
      end
   end

   // Pointers and counts.
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_head_ff  <= '0;
         tx_tail_ff  <= '0;
         rx_head_ff  <= '0;
         rx_tail_ff  <= '0;
         tx_count_ff <= '0;
         rx_count_ff <= '0;
      end else begin
         tx_head_ff  <= tx_head_in;
         tx_tail_ff  <= tx_tail_in;
         rx_head_ff  <= rx_head_in;
         rx_tail_ff  <= rx_tail_in;
         tx_count_ff <= tx_count_in;
         rx_count_ff <= rx_count_in;
      end
   end

   // Transmit queue memory with registered read port.
   always_ff @(posedge clock) begin
      if (cmd.tx_push) begin
         tx_mem_ff[tx_head_ff] <= req_data;
      end
      if (cmd.tx_pop) begin
         tx_rd_ff <= tx_mem_ff[tx_tail_ff];
      end
   end

   // Receive queue memory with registered read port.
   always_ff @(posedge clock) begin
      if (cmd.rx_push) begin
         rx_mem_ff[rx_head_ff] <= req_data;
      end
      if (cmd.rx_pop) begin
         rx_rd_ff <= rx_mem_ff[rx_tail_ff];
      end
   end

   // Result register, loaded either at once or from fetched memory data.
   always_ff @(posedge clock) begin
      if (cmd.load_now) begin
         accepted_ff   <= cmd.accepted;
         read_data_ff  <= '0;
         send_valid_ff <= cmd.send_direct;
         send_data_ff  <= cmd.send_direct ? req_data : 8'd0;
         overrun_ff    <= cmd.overrun;
      end else if (cmd.load_fetch) begin
         accepted_ff   <= cmd.fetch_rx;
         read_data_ff  <= cmd.fetch_rx ? rx_rd_ff : 8'd0;
         send_valid_ff <= !cmd.fetch_rx;
         send_data_ff  <= cmd.fetch_rx ? 8'd0 : tx_rd_ff;
         overrun_ff    <= 1'b0;
      end
   end

   // The levels follow the counts directly.
   assign rsp_accepted   = accepted_ff;
   assign rsp_read_data  = read_data_ff;
   assign rsp_send_valid = send_valid_ff;
   assign rsp_send_data  = send_data_ff;
   assign rsp_overrun    = overrun_ff;
   assign rsp_tx_level   = tx_count_ff;
   assign rsp_rx_level   = rx_count_ff;

`ifndef SYNTHESIS
   // A transmit push never happens on a full or empty queue.
   a_tx_no_overfill: assert property (@(posedge clock) disable iff (reset)
      cmd.tx_push |-> (tx_count_ff != CNT_FULL) && (tx_count_ff != '0))
      else $error("transmit push on a full or idle queue");

   // A receive pop leaves the count one lower.
   a_rx_pop_count: assert property (@(posedge clock) disable iff (reset)
      cmd.rx_pop |=> rx_count_ff == $past(rx_count_ff) - CNT_ONE)
      else $error("receive pop did not lower the count");
`endif

endmodule : utrb_dp

`default_nettype wire

// File: design/utrb_ctrl.sv
// Controller state machine for the ring buffers: handshakes and datapath commands.
`default_nettype none

module utrb_ctrl
   import utrb_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_mode,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire stat_type   stat,
   output cmd_type         cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_FETCH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      fetch_rx_ff, fetch_rx_in;
   logic      accept;
   logic      go_fetch;

   // A new transaction is taken in the idle state when the result register is free or being emptied.
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Decode the event against the queue status.
   always_comb begin
      cmd          = '0;
      go_fetch     = 1'b0;
      cmd.fetch_rx = fetch_rx_ff;
      if (accept) begin
         unique case (mode_type'(req_mode))
            MODE_WRITE: begin
               cmd.load_now = 1'b1;
               if (stat.tx_zero) begin
                  cmd.send_direct = 1'b1;
                  cmd.accepted    = 1'b1;
               end else if (!stat.tx_full) begin
                  cmd.tx_push  = 1'b1;
                  cmd.accepted = 1'b1;
               end
            end
            MODE_READ: begin
               if (stat.rx_zero) begin
                  cmd.load_now = 1'b1;
               end else begin
                  cmd.rx_pop = 1'b1;
                  go_fetch   = 1'b1;
               end
            end
            MODE_RECV: begin
               cmd.load_now = 1'b1;
               if (!stat.rx_full) begin
                  cmd.rx_push  = 1'b1;
                  cmd.accepted = 1'b1;
               end else begin
                  cmd.overrun = 1'b1;
               end
            end
            MODE_DONE: begin
               if (stat.tx_zero) begin
                  cmd.load_now = 1'b1;
               end else if (stat.tx_one) begin
                  cmd.tx_dec   = 1'b1;
                  cmd.load_now = 1'b1;
               end else begin
                  cmd.tx_dec = 1'b1;
                  cmd.tx_pop = 1'b1;
                  go_fetch   = 1'b1;
               end
            end
         endcase
      end
      if (state_ff == ST_FETCH) begin
         cmd.load_fetch = 1'b1;
      end
   end

   // Next state and registered outputs.
   always_comb begin
      state_in    = state_ff;
      fetch_rx_in = fetch_rx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (go_fetch) begin
               state_in    = ST_FETCH;
               fetch_rx_in = cmd.rx_pop;
            end
         end
         ST_FETCH: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.load_now || cmd.load_fetch) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fetch_rx_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fetch_rx_ff  <= fetch_rx_in;
      end
   end

`ifndef SYNTHESIS
   // While memory data is fetched the result register is empty.
   a_fetch_out_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |-> !rsp_valid_ff)
      else $error("result register busy during fetch");

   // A fetch always returns to idle in the next cycle with a result.
   a_fetch_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |=> (state_ff == ST_IDLE) && rsp_valid_ff)
      else $error("fetch did not produce a result");

   // A read with data waiting goes to fetch from the receive queue.
   a_read_fetch: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_mode == MODE_READ) && !stat.rx_zero)
         |=> (state_ff == ST_FETCH) && fetch_rx_ff)
      else $error("read with data did not fetch");
`endif

endmodule : utrb_ctrl

`default_nettype wire

// File: design/uart_tx_rx_ring_buffers.sv
// Top level of the UART transmit and receive ring buffers.
//
// Each request transaction carries one event on req_mode: host write, host
// read, byte received from the line, or transmitter done; req_data holds the
// byte for writes and received bytes. Each request gives exactly one response
// transaction on the rsp_ channel with the accepted flag, read byte, byte to
// load into the transmitter, overrun flag and both queue levels.
// Writes, received bytes, empty reads and done events that leave nothing to
// send give their response in the cycle after acceptance and allow a new
// request every cycle while rsp_ready is high. A read that returns data and
// a done event that hands over a queued byte pass the fetch state for the
// registered read port; the next request is taken once the response loads.
// A finished response waits in the output register; while it is stalled a
// new request is taken only in the cycle in which rsp_ready takes it.
// Synchronous reset empties both queues and clears the pointers; memory
// contents are not cleared and no clearing pass is needed.
`default_nettype none

module uart_tx_rx_ring_buffers
   import utrb_pkg::*;
#(
   parameter int QUEUE_DEPTH = 256
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [1:0]                         req_mode,
   input  wire logic [7:0]                         req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_accepted,
   output logic [7:0]                              rsp_read_data,
   output logic                                    rsp_send_valid,
   output logic [7:0]                              rsp_send_data,
   output logic                                    rsp_overrun,
   output logic [$clog2(QUEUE_DEPTH + 1)-1:0]      rsp_tx_level,
   output logic [$clog2(QUEUE_DEPTH + 1)-1:0]      rsp_rx_level
);

   cmd_type  cmd;
   stat_type stat;

   // Controller: handshakes and event decode.
   utrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: queues and result register.
   utrb_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_data       (req_data),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_accepted   (rsp_accepted),
      .rsp_read_data  (rsp_read_data),
      .rsp_send_valid (rsp_send_valid),
      .rsp_send_data  (rsp_send_data),
      .rsp_overrun    (rsp_overrun),
      .rsp_tx_level   (rsp_tx_level),
      .rsp_rx_level   (rsp_rx_level)
   );

endmodule : uart_tx_rx_ring_buffers

`default_nettype wire
